/* src/ecev_pkg.sv */
`timescale 1ns / 1ps
// ecev_pkg: fixed-point constants, operation codes and the queue entry type
// of the easing curve evaluator. No dependencies; used by every module.
package ecev_pkg;

  // Fixed-point format and port widths.
  localparam int FracBits = 16;
  localparam int KindW    = 4;
  localparam int ProgW    = 20;
  localparam int EasedW   = 18;
  localparam int PW       = FracBits + 1;  // clamped progress, 0..1.0
  localparam int ValW     = FracBits + 2;  // signed curve operand, -1.0..1.0

  // 1.0, the rounding offset and the back-curve constants.
  localparam longint OneL   = longint'(1) << FracBits;
  localparam longint RndL   = longint'(1) << (FracBits - 1);
  localparam longint C1L    = (170158 * OneL + 50000) / 100000;
  localparam longint C2L    = (259490950 * OneL + 50000000) / 100000000;
  localparam longint C3L    = C1L + OneL;
  localparam longint C2P1L  = C2L + OneL;
  localparam longint OutMaxL = (longint'(1) << (EasedW - 1)) - 1;
  localparam longint OutMinL = -(longint'(1) << (EasedW - 1));

  // Queue between the front and the back.
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [KindW-1:0] {
    KIND_LINEAR      = 4'd0,
    KIND_QUAD_IN     = 4'd1,
    KIND_QUAD_OUT    = 4'd2,
    KIND_QUAD_INOUT  = 4'd3,
    KIND_CUBIC_IN    = 4'd4,
    KIND_CUBIC_OUT   = 4'd5,
    KIND_CUBIC_INOUT = 4'd6,
    KIND_QUART_IN    = 4'd7,
    KIND_QUART_OUT   = 4'd8,
    KIND_QUART_INOUT = 4'd9,
    KIND_BACK_IN     = 4'd10,
    KIND_BACK_OUT    = 4'd11,
    KIND_BACK_INOUT  = 4'd12
  } kind_e;

  // Which products the back end forms.
  typedef enum logic [2:0] {
    CURVE_PASS,
    CURVE_QUAD,
    CURVE_CUBIC,
    CURVE_QUART,
    CURVE_BACK_EDGE,
    CURVE_BACK_INOUT
  } curve_e;

  // Rounding shift of the main product, relative to FracBits.
  typedef enum logic [2:0] {
    SH_M3,
    SH_M2,
    SH_M1,
    SH_0,
    SH_P1
  } shift_e;

  // How the final value is formed.
  typedef enum logic [2:0] {
    FIN_PASS,
    FIN_R,
    FIN_ONE_MINUS,
    FIN_ONE_PLUS,
    FIN_BACK_IN,
    FIN_BACK_OUT
  } fin_e;

  typedef struct packed {
    logic signed [ValW-1:0] b;
    curve_e                 curve;
    shift_e                 sh;
    fin_e                   fin;
  } ent_t;

endpackage

/* src/ecev_front.sv */
`timescale 1ns / 1ps
// ecev_front: clamps the progress and turns the ease kind into a queue entry.
// Depends on ecev_pkg.
module ecev_front (
  input  logic [ecev_pkg::KindW-1:0]        kind_i,
  input  logic signed [ecev_pkg::ProgW-1:0] progress_i,
  input  logic                              alive_i,
  output ecev_pkg::ent_t                    ent_o
);

  localparam int ValS = ecev_pkg::ValW + 1;
  localparam logic signed [ValS-1:0] OneS = ValS'(ecev_pkg::OneL);

  logic [ecev_pkg::PW-1:0]     p;
  logic                        lower;
  logic signed [ValS-1:0]      ps;
  logic signed [ValS-1:0]      omp;
  logic signed [ValS-1:0]      pm1;

  always_comb begin
    if (progress_i[ecev_pkg::ProgW-1]) begin
      p = '0;
    end else if (progress_i > ecev_pkg::ProgW'(ecev_pkg::OneL)) begin
      p = ecev_pkg::PW'(ecev_pkg::OneL);
    end else begin
      p = progress_i[ecev_pkg::PW-1:0];
    end
  end

  assign lower = (p < ecev_pkg::PW'(ecev_pkg::RndL));
  assign ps    = signed'({2'b00, p});
  assign omp   = OneS - ps;
  assign pm1   = ps - OneS;

  always_comb begin
    ent_o.b     = ecev_pkg::ValW'(ps);
    ent_o.curve = ecev_pkg::CURVE_PASS;
    ent_o.sh    = ecev_pkg::SH_0;
    ent_o.fin   = ecev_pkg::FIN_PASS;
    case (ecev_pkg::kind_e'(kind_i))
      ecev_pkg::KIND_QUAD_IN, ecev_pkg::KIND_CUBIC_IN, ecev_pkg::KIND_QUART_IN: begin
        ent_o.fin = ecev_pkg::FIN_R;
      end
      ecev_pkg::KIND_QUAD_OUT, ecev_pkg::KIND_CUBIC_OUT, ecev_pkg::KIND_QUART_OUT: begin
        ent_o.b   = ecev_pkg::ValW'(omp);
        ent_o.fin = ecev_pkg::FIN_ONE_MINUS;
      end
      ecev_pkg::KIND_QUAD_INOUT, ecev_pkg::KIND_CUBIC_INOUT,
      ecev_pkg::KIND_QUART_INOUT: begin
        if (lower) begin
          ent_o.fin = ecev_pkg::FIN_R;
        end else begin
          ent_o.b   = ecev_pkg::ValW'(omp <<< 1);
          ent_o.sh  = ecev_pkg::SH_P1;
          ent_o.fin = ecev_pkg::FIN_ONE_MINUS;
        end
      end
      ecev_pkg::KIND_BACK_IN: begin
        ent_o.fin = ecev_pkg::FIN_BACK_IN;
      end
      ecev_pkg::KIND_BACK_OUT: begin
        ent_o.b   = ecev_pkg::ValW'(pm1);
        ent_o.fin = ecev_pkg::FIN_BACK_OUT;
      end
      ecev_pkg::KIND_BACK_INOUT: begin
        ent_o.sh = ecev_pkg::SH_P1;
        if (lower) begin
          ent_o.b   = ecev_pkg::ValW'(ps <<< 1);
          ent_o.fin = ecev_pkg::FIN_R;
        end else begin
          ent_o.b   = ecev_pkg::ValW'(pm1 <<< 1);
          ent_o.fin = ecev_pkg::FIN_ONE_PLUS;
        end
      end
      default: begin
      end
    endcase

    // The curve family and the lower-half shift follow from the kind.
    case (ecev_pkg::kind_e'(kind_i))
      ecev_pkg::KIND_QUAD_IN, ecev_pkg::KIND_QUAD_OUT: begin
        ent_o.curve = ecev_pkg::CURVE_QUAD;
      end
      ecev_pkg::KIND_QUAD_INOUT: begin
        ent_o.curve = ecev_pkg::CURVE_QUAD;
        if (lower) begin
          ent_o.sh = ecev_pkg::SH_M1;
        end
      end
      ecev_pkg::KIND_CUBIC_IN, ecev_pkg::KIND_CUBIC_OUT: begin
        ent_o.curve = ecev_pkg::CURVE_CUBIC;
      end
      ecev_pkg::KIND_CUBIC_INOUT: begin
        ent_o.curve = ecev_pkg::CURVE_CUBIC;
        if (lower) begin
          ent_o.sh = ecev_pkg::SH_M2;
        end
      end
      ecev_pkg::KIND_QUART_IN, ecev_pkg::KIND_QUART_OUT: begin
        ent_o.curve = ecev_pkg::CURVE_QUART;
      end
      ecev_pkg::KIND_QUART_INOUT: begin
        ent_o.curve = ecev_pkg::CURVE_QUART;
        if (lower) begin
          ent_o.sh = ecev_pkg::SH_M3;
        end
      end
      ecev_pkg::KIND_BACK_IN, ecev_pkg::KIND_BACK_OUT: begin
        ent_o.curve = ecev_pkg::CURVE_BACK_EDGE;
      end
      ecev_pkg::KIND_BACK_INOUT: begin
        ent_o.curve = ecev_pkg::CURVE_BACK_INOUT;
      end
      default: begin
      end
    endcase

    // A dead tween passes 1.0 straight through.
    if (!alive_i) begin
      ent_o.b     = ecev_pkg::ValW'(ecev_pkg::OneL);
      ent_o.curve = ecev_pkg::CURVE_PASS;
      ent_o.sh    = ecev_pkg::SH_0;
      ent_o.fin   = ecev_pkg::FIN_PASS;
    end
  end

endmodule

/* src/ecev_queue.sv */
`timescale 1ns / 1ps
// ecev_queue: short flip-flop queue of classified items between front and back.
// Depends on ecev_pkg.
module ecev_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ecev_pkg::ent_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ecev_pkg::ent_t data_o
);

  ecev_pkg::ent_t                 mem_q [ecev_pkg::QDepth];
  logic [ecev_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ecev_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ecev_pkg::QCntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == ecev_pkg::QCntW'(ecev_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ecev_pkg::QPtrW'(ecev_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == ecev_pkg::QPtrW'(ecev_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ecev_pkg::QCntW'(ecev_pkg::QDepth))
    else $error("queue count exceeds its depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i && count_q == ecev_pkg::QCntW'(1)) |=> !valid_o)
    else $error("queue not empty after its last entry left");

endmodule

/* src/ecev_back.sv */
`timescale 1ns / 1ps
// ecev_back: five-stage multiply pipeline that evaluates the curve, plus the
// saturating output register. Depends on ecev_pkg.
module ecev_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  ecev_pkg::ent_t                      q_data_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ecev_pkg::EasedW-1:0]  eased_o
);

  localparam int PW   = ecev_pkg::PW;
  localparam int ValW = ecev_pkg::ValW;
  localparam int MW   = 2 * ValW + 1;   // main product
  localparam int BbW  = 2 * PW - 1;     // square, at most 1.0 squared
  localparam int RW   = ValW + 1;       // rescaled main product
  localparam int ResW = ValW + 4;       // final sum before saturation

  localparam logic signed [RW-1:0]   C2P1S = RW'(ecev_pkg::C2P1L);
  localparam logic signed [RW-1:0]   C3S   = RW'(ecev_pkg::C3L);
  localparam logic [PW-1:0]          C1U   = PW'(ecev_pkg::C1L);
  localparam logic signed [MW:0]     C2S   = (MW + 1)'(ecev_pkg::C2L);
  localparam logic signed [ResW-1:0] OneR  = ResW'(ecev_pkg::OneL);
  localparam logic signed [ResW-1:0] MaxR  = ResW'(ecev_pkg::OutMaxL);
  localparam logic signed [ResW-1:0] MinR  = ResW'(ecev_pkg::OutMinL);

  // Round half up, then arithmetic shift right.
  function automatic logic signed [MW+1:0] rshr(input logic signed [MW:0] x,
                                                input int unsigned s);
    logic signed [MW+1:0] y;
    y = {x[MW], x} + ((MW + 2)'(1) <<< (s - 1));
    rshr = y >>> s;
  endfunction

  logic                         advance;
  logic [4:0]                   vld_q;
  ecev_pkg::ent_t               ctl_q [5];

  // Stage 1: square and the in-out back product.
  logic signed [2*ValW-1:0]     bb_full;
  logic [BbW-1:0]               bb_q;
  logic signed [MW-1:0]         kk_d, kk_q;
  // Stage 2: rescaled square and inner term.
  logic [BbW:0]                 sq_sum;
  logic signed [MW:0]           kk_sum;
  logic [PW-1:0]                sq_d, sq_q;
  logic signed [RW-1:0]         inner_d, inner_q;
  logic [BbW-1:0]               bb2_q;
  // Stage 3: main product and the c1 product.
  logic signed [ValW-1:0]       opa;
  logic signed [RW-1:0]         opb;
  logic signed [MW-1:0]         prod;
  logic signed [MW-1:0]         m_d, m_q;
  logic [2*PW-1:0]              c1sq_d, c1sq_q;
  // Stage 4: rounded main result and c1 term.
  logic signed [MW+1:0]         r_full;
  logic signed [RW-1:0]         r_d, r_q, r5_q;
  logic [2*PW:0]                c1_sum;
  logic [ValW-1:0]              c1t_d, c1t_q, c1t5_q;
  // Stage 5: c3 times the cube.
  logic signed [2*RW-1:0]       c3c_d, c3c_q;
  // Output.
  logic signed [2*RW:0]         c3_sum;
  logic signed [ResW-1:0]       c3t;
  logic signed [ResW-1:0]       res;
  logic signed [ecev_pkg::EasedW-1:0] eased_d, eased_q;
  logic                         out_valid_q;

  assign advance     = !out_valid_q || !out_stall_i;
  assign q_pop_o     = advance && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign eased_o     = eased_q;

  // Stage 1.
  assign bb_full = q_data_i.b * q_data_i.b;
  assign kk_d    = C2P1S * q_data_i.b;

  // Stage 2.
  assign sq_sum  = {1'b0, bb_q} + (BbW + 1)'(ecev_pkg::RndL);
  assign sq_d    = PW'(sq_sum >> ecev_pkg::FracBits);
  assign kk_sum  = {kk_q[MW-1], kk_q} + (MW + 1)'(ecev_pkg::RndL);
  always_comb begin
    if (ctl_q[0].fin == ecev_pkg::FIN_ONE_PLUS) begin
      inner_d = RW'((kk_sum >>> ecev_pkg::FracBits) + C2S);
    end else begin
      inner_d = RW'((kk_sum >>> ecev_pkg::FracBits) - C2S);
    end
  end

  // Stage 3.
  assign opa = signed'({1'b0, sq_q});
  always_comb begin
    case (ctl_q[1].curve)
      ecev_pkg::CURVE_CUBIC, ecev_pkg::CURVE_BACK_EDGE: opb = RW'(ctl_q[1].b);
      ecev_pkg::CURVE_QUART:                            opb = signed'({2'b00, sq_q});
      ecev_pkg::CURVE_BACK_INOUT:                       opb = inner_q;
      default:                                          opb = '0;
    endcase
  end
  assign prod   = opa * opb;
  assign m_d    = (ctl_q[1].curve == ecev_pkg::CURVE_QUAD) ?
                  signed'({{(MW - BbW){1'b0}}, bb2_q}) : prod;
  assign c1sq_d = (2 * PW)'(C1U) * (2 * PW)'(sq_q);

  // Stage 4.
  always_comb begin
    case (ctl_q[2].sh)
      ecev_pkg::SH_M3: r_full = rshr({m_q[MW-1], m_q}, ecev_pkg::FracBits - 3);
      ecev_pkg::SH_M2: r_full = rshr({m_q[MW-1], m_q}, ecev_pkg::FracBits - 2);
      ecev_pkg::SH_M1: r_full = rshr({m_q[MW-1], m_q}, ecev_pkg::FracBits - 1);
      ecev_pkg::SH_P1: r_full = rshr({m_q[MW-1], m_q}, ecev_pkg::FracBits + 1);
      default:         r_full = rshr({m_q[MW-1], m_q}, ecev_pkg::FracBits);
    endcase
  end
  assign r_d    = RW'(r_full);
  assign c1_sum = {1'b0, c1sq_q} + (2 * PW + 1)'(ecev_pkg::RndL);
  assign c1t_d  = ValW'(c1_sum >> ecev_pkg::FracBits);

  // Stage 5.
  assign c3c_d = C3S * r_q;

  // Final combination and saturation.
  assign c3_sum = {c3c_q[2*RW-1], c3c_q} + (2 * RW + 1)'(ecev_pkg::RndL);
  assign c3t    = ResW'(c3_sum >>> ecev_pkg::FracBits);

  always_comb begin
    case (ctl_q[4].fin)
      ecev_pkg::FIN_R:         res = ResW'(r5_q);
      ecev_pkg::FIN_ONE_MINUS: res = OneR - ResW'(r5_q);
      ecev_pkg::FIN_ONE_PLUS:  res = OneR + ResW'(r5_q);
      ecev_pkg::FIN_BACK_IN:   res = c3t - signed'(ResW'(c1t5_q));
      ecev_pkg::FIN_BACK_OUT:  res = OneR + c3t + signed'(ResW'(c1t5_q));
      default:                 res = ResW'(ctl_q[4].b);
    endcase
    if (res > MaxR) begin
      eased_d = ecev_pkg::EasedW'(MaxR);
    end else if (res < MinR) begin
      eased_d = ecev_pkg::EasedW'(MinR);
    end else begin
      eased_d = ecev_pkg::EasedW'(res);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      vld_q       <= {vld_q[3:0], q_valid_i};
      out_valid_q <= vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl_q[0] <= q_data_i;
      ctl_q[1] <= ctl_q[0];
      ctl_q[2] <= ctl_q[1];
      ctl_q[3] <= ctl_q[2];
      ctl_q[4] <= ctl_q[3];
      bb_q     <= bb_full[BbW-1:0];
      kk_q     <= kk_d;
      sq_q     <= sq_d;
      inner_q  <= inner_d;
      bb2_q    <= bb_q;
      m_q      <= m_d;
      c1sq_q   <= c1sq_d;
      r_q      <= r_d;
      c1t_q    <= c1t_d;
      c3c_q    <= c3c_d;
      r5_q     <= r_q;
      c1t5_q   <= c1t_q;
      eased_q  <= eased_d;
    end
  end

  a_last_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && vld_q[4]) |=> out_valid_q)
    else $error("item in the last stage did not reach the output register");

  a_freeze_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(vld_q) && $stable(eased_q)))
    else $error("pipeline moved while the output was stalled");

  a_pop_only_advancing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && !vld_q[0]) |=> (vld_q[0] || vld_q[1]))
    else $error("popped item did not enter the pipeline");

endmodule

/* src/easing_curve_evaluator_core.sv */
`timescale 1ns / 1ps
// easing_curve_evaluator_core: top level of the easing curve evaluator.
// Instantiates ecev_front, ecev_queue and ecev_back; depends on ecev_pkg.
//
// Usage: each transfer on the input channel (in_valid_i high, in_stall_o low)
// carries an ease kind, a signed Q3.16 progress and an alive flag. Exactly
// one signed Q1.16 eased value leaves per item on the output channel, in the
// same order, transferred when out_valid_o is high and out_stall_i is low.
// Progress is clamped to 0..1.0; quad, cubic, quart and back curves in their
// in, out and in-out forms are supported, unknown kinds act as linear and a
// dead tween gives 1.0. Results are saturated to the 18-bit output range.
// Throughput is one item per clock cycle while the output is not stalled. The
// front classifies the item in the cycle of its transfer and writes a two-entry
// queue; the back is a five-stage multiply pipeline followed by the output
// register. The multiply chain of the back curves (square, cube, times c3)
// sets the pipeline depth. When the receiver stalls a valid output, the back
// pipeline freezes and the output holds; the queue then absorbs up to two more
// items before in_stall_o rises. Reset, asynchronous and active low, empties
// the queue and the pipeline and drops any item held in them; no item is
// produced by it, and the block is ready right after.
module easing_curve_evaluator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ecev_pkg::KindW-1:0]          kind_i,
  input  logic signed [ecev_pkg::ProgW-1:0]   progress_i,
  input  logic                                alive_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ecev_pkg::EasedW-1:0]  eased_o
);

  ecev_pkg::ent_t front_ent;
  ecev_pkg::ent_t q_data;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           push;

  // The input stalls only on a full queue, which is a registered condition.
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  ecev_front u_front (
    .kind_i     (kind_i),
    .progress_i (progress_i),
    .alive_i    (alive_i),
    .ent_o      (front_ent)
  );

  ecev_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_ent),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  ecev_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .eased_o     (eased_o)
  );

endmodule

/* tb/ecev_checker.sv */
`timescale 1ns / 1ps
// ecev_checker: watches both channels of the easing curve evaluator, predicts each eased
// value and compares it with the block's output. Depends on ecev_pkg for widths and kinds.
module ecev_checker
  import ecev_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [KindW-1:0]           kind_i,
  input  logic signed [ProgW-1:0]    progress_i,
  input  logic                       alive_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [EasedW-1:0]   eased_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam longint Unit  = longint'(1) << FracBits;
  localparam longint Half  = Unit >> 1;
  localparam longint BackK1 = (170158 * Unit + 50000) / 100000;
  localparam longint BackK2 = (259490950 * Unit + 50000000) / 100000000;
  localparam longint BackK3 = BackK1 + Unit;
  localparam longint SatHi = (longint'(1) << (EasedW - 1)) - 1;
  localparam longint SatLo = -(longint'(1) << (EasedW - 1));

  typedef struct {
    logic [KindW-1:0]         kind;
    logic signed [ProgW-1:0]  progress;
    logic                     alive;
    logic signed [EasedW-1:0] eased;
  } eased_due_t;

  eased_due_t eased_due[$];

  // Floor of x / 2^s after adding half an LSB.
  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return round_shift(a * b, FracBits);
  endfunction

  function automatic logic signed [EasedW-1:0] ease_value(logic [KindW-1:0] kind,
                                                          logic signed [ProgW-1:0] progress,
                                                          logic alive);
    longint p, p2, t, t2, q, inner, r;
    p = longint'(progress);
    if (p < 0) p = 0;
    if (p > Unit) p = Unit;
    p2 = mulq(p, p);
    case (kind)
      KIND_QUAD_IN:  r = p2;
      KIND_QUAD_OUT: begin
        t = Unit - p;
        r = Unit - mulq(t, t);
      end
      KIND_QUAD_INOUT: begin
        if (p < Half) begin
          r = round_shift(p * p, FracBits - 1);
        end else begin
          t = 2 * Unit - 2 * p;
          r = Unit - round_shift(t * t, FracBits + 1);
        end
      end
      KIND_CUBIC_IN:  r = mulq(p2, p);
      KIND_CUBIC_OUT: begin
        t = Unit - p;
        r = Unit - mulq(mulq(t, t), t);
      end
      KIND_CUBIC_INOUT: begin
        if (p < Half) begin
          r = round_shift(p2 * p, FracBits - 2);
        end else begin
          t = 2 * Unit - 2 * p;
          r = Unit - round_shift(mulq(t, t) * t, FracBits + 1);
        end
      end
      KIND_QUART_IN:  r = mulq(p2, p2);
      KIND_QUART_OUT: begin
        t = Unit - p;
        t2 = mulq(t, t);
        r = Unit - mulq(t2, t2);
      end
      KIND_QUART_INOUT: begin
        if (p < Half) begin
          r = round_shift(p2 * p2, FracBits - 3);
        end else begin
          t = 2 * Unit - 2 * p;
          t2 = mulq(t, t);
          r = Unit - round_shift(t2 * t2, FracBits + 1);
        end
      end
      KIND_BACK_IN:  r = mulq(BackK3, mulq(p2, p)) - mulq(BackK1, p2);
      KIND_BACK_OUT: begin
        t = p - Unit;
        t2 = mulq(t, t);
        r = Unit + mulq(BackK3, mulq(t2, t)) + mulq(BackK1, t2);
      end
      KIND_BACK_INOUT: begin
        if (p < Half) begin
          q = 2 * p;
          inner = mulq(BackK2 + Unit, q) - BackK2;
          r = round_shift(mulq(q, q) * inner, FracBits + 1);
        end else begin
          q = 2 * p - 2 * Unit;
          inner = mulq(BackK2 + Unit, q) + BackK2;
          r = Unit + round_shift(mulq(q, q) * inner, FracBits + 1);
        end
      end
      default: r = p;
    endcase
    if (!alive) r = Unit;
    if (r > SatHi) r = SatHi;
    if (r < SatLo) r = SatLo;
    return r[EasedW-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    eased_due_t head;
    if (!rst_ni) begin
      fail_count_o = 0;
      eased_due.delete();
    end else begin
      // The result side is checked first so that an item and its own result never meet here.
      if (out_valid_i && !out_stall_i) begin
        if (eased_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result eased=%0d", eased_i));
        end else begin
          head = eased_due.pop_front();
          if (eased_i !== head.eased)
            report_mismatch($sformatf("kind=%0d progress=%0d alive=%0b eased=%0d want %0d",
                                      head.kind, head.progress, head.alive, eased_i,
                                      head.eased));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        head.kind = kind_i;
        head.progress = progress_i;
        head.alive = alive_i;
        head.eased = ease_value(kind_i, progress_i, alive_i);
        eased_due.push_back(head);
      end
    end
    pending_o = eased_due.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for easing_curve_evaluator_core. Depends on ecev_pkg,
// the core and ecev_checker, which does all prediction and comparison.
module tb_top;
  import ecev_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 950;
  localparam int HoldCycles  = 90;
  localparam int DrainCycles = 20;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [KindW-1:0]          kind_i;
  logic signed [ProgW-1:0]   progress_i;
  logic                      alive_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [EasedW-1:0]  eased_o;

  int fail_count;
  int pending;
  int cycle_count;

  // Flow control knobs. The sender and the receiver idle at random unless told to keep
  // quiet; a hold request makes the receiver stall for a long counted stretch.
  bit send_quiet;
  bit recv_quiet;
  int hold_asks;
  int hold_served;
  int hold_left;

  easing_curve_evaluator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .progress_i (progress_i),
    .alive_i    (alive_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .eased_o    (eased_o)
  );

  ecev_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .kind_i      (kind_i),
    .progress_i  (progress_i),
    .alive_i     (alive_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .eased_i     (eased_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is bounded by a plain cycle counter; running past it is a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("easing_curve_evaluator_core regression: fail");
      $finish;
    end
  end

  // The receiver decides its stall at every falling edge. A pending hold request turns
  // into a long stall counted here, during which the block fills up.
  initial begin
    out_stall_i = 1'b1;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (recv_quiet) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(99) < 29);
      end
    end
  end

  // Offers one item and returns at the falling edge after its transfer. Called at a
  // falling edge. Valid stays high from one item to the next when no gap is drawn.
  task automatic send_easing(input logic [KindW-1:0] kind, input logic signed [ProgW-1:0] prog,
                             input logic alive);
    if (!send_quiet) begin
      while ($urandom_range(99) < 29) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    progress_i = prog;
    alive_i = alive;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly progress inside 0..1.0 where the curves live, some right at the clamp edges
  // and the half point, and the rest spread over the whole 20-bit range.
  function automatic logic signed [ProgW-1:0] random_progress();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return ProgW'($urandom_range(65536));
    if (pick < 70) return ProgW'(32768 + $signed($urandom_range(8)) - 4);
    if (pick < 80) return ProgW'(65536 + $signed($urandom_range(8)) - 4);
    if (pick < 85) return ProgW'($signed($urandom_range(8)) - 4);
    return ProgW'($urandom);
  endfunction

  initial begin
    logic [KindW-1:0] kind;
    in_valid_i = 1'b0;
    kind_i = '0;
    progress_i = '0;
    alive_i = 1'b0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    hold_asks = 0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: every kind, unknown ones included, at the half point where the
    // in-out forms switch halves, then the clamp edges and dead tweens.
    for (int k = 0; k < 16; k++) send_easing(KindW'(k), ProgW'(32768), 1'b1);
    send_easing(KIND_BACK_INOUT, ProgW'(32767), 1'b1);
    send_easing(KIND_QUAD_OUT, ProgW'(-524288), 1'b1);
    send_easing(KIND_BACK_OUT, ProgW'(524287), 1'b1);
    send_easing(KIND_BACK_IN, ProgW'(65536), 1'b1);
    send_easing(KIND_BACK_INOUT, ProgW'(0), 1'b1);
    send_easing(KIND_CUBIC_INOUT, ProgW'(65535), 1'b1);
    send_easing(KIND_QUART_INOUT, ProgW'(65537), 1'b1);
    send_easing(KIND_LINEAR, ProgW'(-1), 1'b0);
    send_easing(KIND_BACK_INOUT, ProgW'(524287), 1'b0);

    // Random part. One window keeps the sender busy through a long receiver hold-off,
    // another runs with no idling on either side at all.
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 300) begin
        send_quiet = 1'b1;
        hold_asks++;
      end
      if (n == 420) send_quiet = 1'b0;
      if (n == 550) begin
        send_quiet = 1'b1;
        recv_quiet = 1'b1;
      end
      if (n == 700) begin
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
      end
      kind = KindW'($urandom_range(15));
      send_easing(kind, random_progress(), ($urandom_range(99) < 90));
    end
    in_valid_i = 1'b0;

    // Drain: wait for every result, then a few more cycles to catch anything extra.
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("easing_curve_evaluator_core regression: pass");
    end else begin
      $display("easing_curve_evaluator_core regression: fail");
    end
    $finish;
  end

endmodule
